// File: hw/rtl/sdpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_pkg
// Shared types, codes and sizes for the send descriptor pool allocator.
// ----------------------------------------------------------------------------
package sdpa_pkg;

	localparam int MAX_DESC  = 64;
	localparam int MAX_BUF   = 64;
	localparam int MAX_BATCH = 16;

	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;
	localparam int SIZE_W  = 16;
	localparam int KIND_W  = 2;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int REQ_W   = 5;
	localparam int REG_W   = 16;
	localparam int REGIX_W = 2;
	localparam int DESC_AW  = $clog2(MAX_DESC);
	localparam int BUF_AW   = $clog2(MAX_BUF);
	localparam int BATCH_W  = $clog2(MAX_BATCH + 1);
	localparam int ATT_W    = KIND_W + IDX_W;

	localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALLOC_PAY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FREE      = 2'd2;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_IMM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POOL = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_DESC = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_BUF  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_IDX = 2'd3;

	localparam logic [REGIX_W-1:0] REG_DESC_COUNT = 2'd0;
	localparam logic [REGIX_W-1:0] REG_BUF_COUNT  = 2'd1;
	localparam logic [REGIX_W-1:0] REG_IMM_SIZE   = 2'd2;
	localparam logic [REGIX_W-1:0] REG_BUF_SIZE   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALLOC,
		ST_FREE
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]  desc_count;
		logic [CNT_W-1:0]  buf_count;
		logic [SIZE_W-1:0] imm_size;
		logic [SIZE_W-1:0] buf_size;
		logic              desc_init;
		logic              buf_init;
		logic [CNT_W-1:0]  init_count;
	} cfg_t;

	typedef struct packed {
		logic              strobe;
		logic              desc_valid;
		logic [IDX_W-1:0]  desc_index;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  buf_index;
		logic [SIZE_W-1:0] size;
		logic              ack;
		logic [STAT_W-1:0] status;
		logic              became;
		logic              avail;
		logic              last;
	} result_t;

endpackage

// File: hw/rtl/sdpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sdpa_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/sdpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpa_ctrl
// Sequencer: stack pointers, entry valid bits and read-modify-write steps.
// ----------------------------------------------------------------------------
module sdpa_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sdpa_pkg::MODE_W-1:0]    mode,
	input  logic [sdpa_pkg::REQ_W-1:0]     alloc_count,
	input  logic [sdpa_pkg::SIZE_W-1:0]    payload_length,
	input  logic [sdpa_pkg::IDX_W-1:0]     free_index,
	input  sdpa_pkg::cfg_t                 cfg,
	output logic                           dstk_we,
	output logic [sdpa_pkg::DESC_AW-1:0]   dstk_waddr,
	output logic [sdpa_pkg::IDX_W-1:0]     dstk_wdata,
	output logic [sdpa_pkg::DESC_AW-1:0]   dstk_raddr,
	input  logic [sdpa_pkg::IDX_W-1:0]     dstk_rdata,
	output logic                           bstk_we,
	output logic [sdpa_pkg::BUF_AW-1:0]    bstk_waddr,
	output logic [sdpa_pkg::IDX_W-1:0]     bstk_wdata,
	output logic [sdpa_pkg::BUF_AW-1:0]    bstk_raddr,
	input  logic [sdpa_pkg::IDX_W-1:0]     bstk_rdata,
	output logic                           att_we,
	output logic [sdpa_pkg::DESC_AW-1:0]   att_waddr,
	output logic [sdpa_pkg::ATT_W-1:0]     att_wdata,
	output logic [sdpa_pkg::DESC_AW-1:0]   att_raddr,
	input  logic [sdpa_pkg::ATT_W-1:0]     att_rdata,
	output sdpa_pkg::result_t              res
);
	import sdpa_pkg::*;

	state_t state_q, state_d;

	logic [MODE_W-1:0]  mode_q;
	logic [BATCH_W-1:0] cnt_q;
	logic [BATCH_W-1:0] k_q;
	logic [SIZE_W-1:0]  len_q;
	logic [IDX_W-1:0]   fidx_q;
	logic [CNT_W-1:0]   dtot_q, dtot_d;
	logic [CNT_W-1:0]   btot_q, btot_d;

	// per-entry valid bits; an invalid stack entry reads as its own address
	logic [MAX_DESC-1:0] dvalid_q;
	logic [MAX_BUF-1:0]  bvalid_q;
	logic [MAX_DESC-1:0] kvalid_q;   // attached kind written since desc init
	logic [MAX_DESC-1:0] kbvalid_q;  // attached kind written since buf init

	logic [CNT_W-1:0]   dtot_m1, btot_m1;
	logic [BATCH_W-1:0] req_sat;
	logic               idx_ok;
	logic               need_buf;
	logic               stop_desc, stop_buf;
	logic [IDX_W-1:0]   pop_desc, pop_buf;
	logic [KIND_W-1:0]  att_kind, eff_kind;
	logic [IDX_W-1:0]   att_buf;
	logic               batch_end;

	assign dtot_m1    = dtot_q - 1'b1;
	assign btot_m1    = btot_q - 1'b1;
	assign dstk_raddr = dtot_m1[DESC_AW-1:0];
	assign bstk_raddr = btot_m1[BUF_AW-1:0];
	assign att_raddr  = DESC_AW'(free_index);

	assign req_sat   = (alloc_count > REQ_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH)
	                                                     : BATCH_W'(alloc_count);
	assign idx_ok    = ({1'b0, free_index} < cfg.desc_count);
	assign need_buf  = (mode_q == MODE_ALLOC_PAY) && (len_q > cfg.imm_size);
	assign stop_desc = (dtot_q == '0);
	assign stop_buf  = need_buf && (btot_q == '0);
	assign batch_end = (BATCH_W'(k_q + 1'b1) == cnt_q);

	assign pop_desc = dvalid_q[dstk_raddr] ? dstk_rdata : IDX_W'(dstk_raddr);
	assign pop_buf  = bvalid_q[bstk_raddr] ? bstk_rdata : IDX_W'(bstk_raddr);

	assign att_kind = att_rdata[ATT_W-1 -: KIND_W];
	assign att_buf  = att_rdata[IDX_W-1:0];
	always_comb begin
		eff_kind = att_kind;
		if (!kvalid_q[fidx_q[DESC_AW-1:0]]) begin
			eff_kind = KIND_NONE;
		end else if (att_kind == KIND_POOL && !kbvalid_q[fidx_q[DESC_AW-1:0]]) begin
			eff_kind = KIND_NONE;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mode == MODE_FREE && idx_ok) begin
						state_d = ST_FREE;
					end else if ((mode == MODE_ALLOC || mode == MODE_ALLOC_PAY)
					             && req_sat != '0) begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (stop_desc || stop_buf) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_ALLOC;
				end
			end
			ST_ALLOC: begin
				state_d = batch_end ? ST_IDLE : ST_CHECK;
			end
			ST_FREE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and memory writes
	always_comb begin
		res        = '0;
		res.avail  = (dtot_q != '0) && (btot_q != '0);
		dtot_d     = dtot_q;
		btot_d     = btot_q;
		dstk_we    = 1'b0;
		dstk_waddr = dtot_q[DESC_AW-1:0];
		dstk_wdata = fidx_q;
		bstk_we    = 1'b0;
		bstk_waddr = btot_q[BUF_AW-1:0];
		bstk_wdata = att_buf;
		att_we     = 1'b0;
		att_waddr  = pop_desc[DESC_AW-1:0];
		att_wdata  = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_FREE: begin
							if (!idx_ok) begin
								res.strobe = 1'b1;
								res.status = STAT_BAD_IDX;
								res.last   = 1'b1;
							end
						end
						MODE_ALLOC, MODE_ALLOC_PAY: begin
							if (req_sat == '0) begin
								res.strobe = 1'b1;
								res.last   = 1'b1;
							end
						end
						default: begin
							res.strobe = 1'b1;
							res.last   = 1'b1;
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (stop_desc) begin
					res.strobe = 1'b1;
					res.status = STAT_NO_DESC;
					res.last   = 1'b1;
				end else if (stop_buf) begin
					res.strobe = 1'b1;
					res.status = STAT_NO_BUF;
					res.last   = 1'b1;
				end
			end
			ST_ALLOC: begin
				dtot_d         = dtot_m1;
				res.strobe     = 1'b1;
				res.desc_valid = 1'b1;
				res.desc_index = pop_desc;
				res.last       = batch_end;
				if (need_buf) begin
					btot_d        = btot_m1;
					res.kind      = KIND_POOL;
					res.buf_index = pop_buf;
					res.size      = cfg.buf_size;
				end else if (mode_q == MODE_ALLOC_PAY) begin
					res.kind = KIND_IMM;
					res.size = cfg.imm_size;
				end
				res.ack = (dtot_d < (cfg.desc_count >> 1))
				          || (need_buf && btot_d < (cfg.buf_count >> 1));
				res.avail = (dtot_d != '0) && (btot_d != '0);
				att_we    = 1'b1;
				att_wdata = {res.kind, pop_buf};
			end
			ST_FREE: begin
				att_we    = 1'b1;
				att_waddr = fidx_q[DESC_AW-1:0];
				att_wdata = {KIND_NONE, att_buf};
				if (eff_kind == KIND_POOL && btot_q < cfg.buf_count) begin
					bstk_we = 1'b1;
					btot_d  = btot_q + 1'b1;
				end
				if (dtot_q < cfg.desc_count) begin
					dstk_we    = 1'b1;
					dtot_d     = dtot_q + 1'b1;
					res.became = (dtot_q == '0);
				end
				res.strobe = 1'b1;
				res.last   = 1'b1;
				res.avail  = (dtot_d != '0) && (btot_d != '0);
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dtot_q    <= CNT_W'(MAX_DESC);
			btot_q    <= CNT_W'(MAX_BUF);
			dvalid_q  <= '0;
			bvalid_q  <= '0;
			kvalid_q  <= '0;
			kbvalid_q <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
		end else begin
			state_q <= state_d;
			dtot_q  <= dtot_d;
			btot_q  <= btot_d;
			if (state_q == ST_IDLE && start) begin
				cnt_q <= req_sat;
				k_q   <= '0;
			end else if (state_q == ST_ALLOC) begin
				k_q <= BATCH_W'(k_q + 1'b1);
			end
			if (dstk_we) begin
				dvalid_q[dstk_waddr] <= 1'b1;
			end
			if (bstk_we) begin
				bvalid_q[bstk_waddr] <= 1'b1;
			end
			if (att_we) begin
				kvalid_q[att_waddr]  <= 1'b1;
				kbvalid_q[att_waddr] <= 1'b1;
			end
			// user must reinit only while idle; the block does not enforce it. Reinit simply overrides
			if (cfg.desc_init) begin
				dtot_q   <= cfg.init_count;
				dvalid_q <= '0;
				kvalid_q <= '0;
			end
			if (cfg.buf_init) begin
				btot_q    <= cfg.init_count;
				bvalid_q  <= '0;
				kbvalid_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			mode_q <= mode;
			len_q  <= payload_length;
			fidx_q <= free_index;
		end
	end

endmodule

// File: hw/rtl/send_descriptor_pool_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// send_descriptor_pool_allocator
// Two LIFO free lists (descriptors, pool buffers) with batch alloc and free.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  -------   ------------------------  ---------------------------------------
//  request   start / busy              mode, alloc_count, payload_length,
//                                      free_index
//  result    result_strobe (1 cycle)   descriptor_valid .. last
//  config    reg_write                 reg_index, reg_data
//
//  A request is taken when start is high and busy low. For an alloc of n
//  descriptors, the check state issues each registered stack read and
//  the alloc state pops and writes metadata. An early stop ends in check;
//  a free runs the free state; zero count, mode 3 and a bad free index
//  answer from idle. Results appear in the cycle after their step and
//  cannot be held off. Reset restores all counts at once (valid bits per
//  entry), no clearing pass; count writes reinitialise the same way.
// ----------------------------------------------------------------------------
module send_descriptor_pool_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sdpa_pkg::MODE_W-1:0]    mode,
	input  logic [sdpa_pkg::REQ_W-1:0]     alloc_count,
	input  logic [sdpa_pkg::SIZE_W-1:0]    payload_length,
	input  logic [sdpa_pkg::IDX_W-1:0]     free_index,
	input  logic                           reg_write,
	input  logic [sdpa_pkg::REGIX_W-1:0]   reg_index,
	input  logic [sdpa_pkg::REG_W-1:0]     reg_data,
	output logic                           result_strobe,
	output logic                           descriptor_valid,
	output logic [sdpa_pkg::IDX_W-1:0]     descriptor_index,
	output logic [sdpa_pkg::KIND_W-1:0]    payload_kind,
	output logic [sdpa_pkg::IDX_W-1:0]     buffer_index,
	output logic [sdpa_pkg::SIZE_W-1:0]    payload_size,
	output logic                           ack_request,
	output logic [sdpa_pkg::STAT_W-1:0]    status,
	output logic                           became_available,
	output logic                           available,
	output logic                           last
);
	import sdpa_pkg::*;

	// configuration registers
	logic [CNT_W-1:0]  desc_count_q;
	logic [CNT_W-1:0]  buf_count_q;
	logic [SIZE_W-1:0] imm_size_q;
	logic [SIZE_W-1:0] buf_size_q;
	logic [CNT_W-1:0]  wr_count;
	logic [CNT_W-1:0]  desc_sat;
	logic [CNT_W-1:0]  buf_sat;
	logic              desc_wr;
	logic              buf_wr;
	cfg_t              cfg;

	// descriptor count clamps to 1..MAX_DESC, buffer count to 0..MAX_BUF
	assign wr_count = reg_data[CNT_W-1:0];
	assign desc_sat = (wr_count == '0) ? CNT_W'(1)
	                : (wr_count > CNT_W'(MAX_DESC)) ? CNT_W'(MAX_DESC) : wr_count;
	assign buf_sat  = (wr_count > CNT_W'(MAX_BUF)) ? CNT_W'(MAX_BUF) : wr_count;
	assign desc_wr  = reg_write && (reg_index == REG_DESC_COUNT);
	assign buf_wr   = reg_write && (reg_index == REG_BUF_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_count_q <= CNT_W'(MAX_DESC);
			buf_count_q  <= CNT_W'(MAX_BUF);
			imm_size_q   <= '0;
			buf_size_q   <= SIZE_W'(2048);
		end else if (reg_write) begin
			case (reg_index)
				REG_DESC_COUNT: desc_count_q <= desc_sat;
				REG_BUF_COUNT:  buf_count_q  <= buf_sat;
				REG_IMM_SIZE:   imm_size_q   <= reg_data;
				REG_BUF_SIZE:   buf_size_q   <= reg_data;
				default: begin
					desc_count_q <= desc_count_q;
				end
			endcase
		end
	end

	always_comb begin
		cfg            = '0;
		cfg.desc_count = desc_count_q;
		cfg.buf_count  = buf_count_q;
		cfg.imm_size   = imm_size_q;
		cfg.buf_size   = buf_size_q;
		cfg.desc_init  = desc_wr;
		cfg.buf_init   = buf_wr;
		cfg.init_count = desc_wr ? desc_sat : buf_sat;
	end

	// memories: free descriptor stack, free buffer stack, attachment per descriptor
	logic                dstk_we, bstk_we, att_we;
	logic [DESC_AW-1:0]  dstk_waddr, dstk_raddr, att_waddr, att_raddr;
	logic [BUF_AW-1:0]   bstk_waddr, bstk_raddr;
	logic [IDX_W-1:0]    dstk_wdata, dstk_rdata, bstk_wdata, bstk_rdata;
	logic [ATT_W-1:0]    att_wdata, att_rdata;
	result_t             res;

	sdpa_ram #(.DEPTH(MAX_DESC), .WIDTH(IDX_W)) u_desc_stack (
		.clk   (clk),
		.we    (dstk_we),
		.waddr (dstk_waddr),
		.wdata (dstk_wdata),
		.raddr (dstk_raddr),
		.rdata (dstk_rdata)
	);

	sdpa_ram #(.DEPTH(MAX_BUF), .WIDTH(IDX_W)) u_buf_stack (
		.clk   (clk),
		.we    (bstk_we),
		.waddr (bstk_waddr),
		.wdata (bstk_wdata),
		.raddr (bstk_raddr),
		.rdata (bstk_rdata)
	);

	sdpa_ram #(.DEPTH(MAX_DESC), .WIDTH(ATT_W)) u_attach (
		.clk   (clk),
		.we    (att_we),
		.waddr (att_waddr),
		.wdata (att_wdata),
		.raddr (att_raddr),
		.rdata (att_rdata)
	);

	sdpa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.alloc_count    (alloc_count),
		.payload_length (payload_length),
		.free_index     (free_index),
		.cfg            (cfg),
		.dstk_we        (dstk_we),
		.dstk_waddr     (dstk_waddr),
		.dstk_wdata     (dstk_wdata),
		.dstk_raddr     (dstk_raddr),
		.dstk_rdata     (dstk_rdata),
		.bstk_we        (bstk_we),
		.bstk_waddr     (bstk_waddr),
		.bstk_wdata     (bstk_wdata),
		.bstk_raddr     (bstk_raddr),
		.bstk_rdata     (bstk_rdata),
		.att_we         (att_we),
		.att_waddr      (att_waddr),
		.att_wdata      (att_wdata),
		.att_raddr      (att_raddr),
		.att_rdata      (att_rdata),
		.res            (res)
	);

	// result word register: strobe is control, the rest is payload
	logic    strobe_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.strobe;
		end
	end

	always_ff @(posedge clk) begin
		if (res.strobe) begin
			res_q <= res;
		end
	end

	assign result_strobe    = strobe_q;
	assign descriptor_valid = res_q.desc_valid;
	assign descriptor_index = res_q.desc_index;
	assign payload_kind     = res_q.kind;
	assign buffer_index     = res_q.buf_index;
	assign payload_size     = res_q.size;
	assign ack_request      = res_q.ack;
	assign status           = res_q.status;
	assign became_available = res_q.became;
	assign available        = res_q.avail;
	assign last             = res_q.last;

endmodule
